// File: rtl/core/tmp_pkg.sv
// Shared widths, formats and register indexes for the trapezoid motion profile.
`timescale 1ns / 1ps
package tmp_pkg;

  localparam int unsigned TICK_W = 16;   // unsigned Q0.16 seconds
  localparam int unsigned RATE_W = 32;   // signed Q16.16
  localparam int unsigned DIST_W = 31;   // unsigned Q15.16
  localparam int unsigned FRAC_W = 16;   // fraction bits of the tick
  localparam int unsigned PROD_W = RATE_W + TICK_W + 1;

  typedef enum logic [2:0] {
    REG_TOTAL   = 3'd0,
    REG_ENDLESS = 3'd1,
    REG_ACCEL   = 3'd2,
    REG_DECEL   = 3'd3,
    REG_HIGH    = 3'd4,
    REG_LOW     = 3'd5,
    REG_BRAKE   = 3'd6
  } reg_idx_t;

endpackage

// File: rtl/core/trapezoid_motion_profile.sv
// Trapezoid motion profile: one tick in, one step/speed/distance result out.
// Path from input transfer to m_tvalid: ramp state, then push when not moving;
// when moving, add and step, then fin only when the new speed is positive, then push;
// its length is set by the two dependent passes through the single shared multiplier.
// Ticks are taken only in idle; a waiting result stalls only the final load.
// Reset (rst, synchronous): registers, speed and distance done clear to zero.
`timescale 1ns / 1ps
module trapezoid_motion_profile (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // tick input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] tick_seconds
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata    // [30:0] step_distance, [62:31] speed_now,
                                 // [93:63] travelled, [95:94] zero
);

  localparam int unsigned RW = tmp_pkg::RATE_W;
  localparam int unsigned DW = tmp_pkg::DIST_W;
  localparam int unsigned TW = tmp_pkg::TICK_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAMP,
    ST_ADD,
    ST_STEP,
    ST_FIN,
    ST_PUSH
  } state_t;

  // configuration registers
  logic        [DW-1:0] total_distance;
  logic                 endless_mode;
  logic signed [RW-1:0] accel_rate;
  logic signed [RW-1:0] decel_rate;
  logic signed [RW-1:0] high_speed;
  logic signed [RW-1:0] low_speed;
  logic signed [RW-1:0] braking_zone;

  state_t               state;
  logic signed [RW-1:0] velocity;
  logic        [DW-1:0] done_dist;
  logic        [TW-1:0] tick;
  logic signed [RW:0]   left;
  logic                 accel_on;
  logic                 decel_on;
  logic        [DW-1:0] step;

  logic                 cfg_wr;
  logic signed [RW-1:0] mul_a;
  logic signed [RW-1:0] prod;
  logic signed [RW:0]   brake33;
  logic                 moving;
  logic                 accel_c;
  logic                 decel_c;
  logic signed [RW:0]   speed_sum;
  logic signed [RW-1:0] speed_next;
  logic        [DW-1:0] step_next;
  logic        [DW:0]   done_sum;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      total_distance <= '0;
      endless_mode   <= 1'b0;
      accel_rate     <= '0;
      decel_rate     <= '0;
      high_speed     <= '0;
      low_speed      <= '0;
      braking_zone   <= '0;
    end else if (cfg_wr) begin
      case (tmp_pkg::reg_idx_t'(paddr[4:2]))
        tmp_pkg::REG_TOTAL:   total_distance <= pwdata[DW-1:0];
        tmp_pkg::REG_ENDLESS: endless_mode   <= pwdata[0];
        tmp_pkg::REG_ACCEL:   accel_rate     <= $signed(pwdata);
        tmp_pkg::REG_DECEL:   decel_rate     <= $signed(pwdata);
        tmp_pkg::REG_HIGH:    high_speed     <= $signed(pwdata);
        tmp_pkg::REG_LOW:     low_speed      <= $signed(pwdata);
        tmp_pkg::REG_BRAKE:   braking_zone   <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (tmp_pkg::reg_idx_t'(paddr[4:2]))
      tmp_pkg::REG_TOTAL:   prdata = {1'b0, total_distance};
      tmp_pkg::REG_ENDLESS: prdata = {31'd0, endless_mode};
      tmp_pkg::REG_ACCEL:   prdata = accel_rate;
      tmp_pkg::REG_DECEL:   prdata = decel_rate;
      tmp_pkg::REG_HIGH:    prdata = high_speed;
      tmp_pkg::REG_LOW:     prdata = low_speed;
      tmp_pkg::REG_BRAKE:   prdata = braking_zone;
      default:              prdata = '0;
    endcase
  end

  // ramp decisions, evaluated in the ramp state
  always_comb begin
    brake33 = {braking_zone[RW-1], braking_zone};
    moving  = (left > $signed({(RW+1){1'b0}})) || endless_mode;
    accel_c = (accel_rate > 0) && (velocity < high_speed) && (left > brake33);
    decel_c = (decel_rate < 0) && (velocity > low_speed) && !(left > brake33);
  end

  // operand select for the shared multiplier
  always_comb begin
    if (state == ST_STEP) begin
      mul_a = velocity;
    end else if (accel_c) begin
      mul_a = accel_rate;
    end else begin
      mul_a = decel_rate;
    end
  end

  tmp_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .dt   (tick),
    .prod (prod)
  );

  // speed update with clamp
  always_comb begin
    speed_sum = {velocity[RW-1], velocity} + {prod[RW-1], prod};
    if (accel_on) begin
      speed_next = (speed_sum > $signed({high_speed[RW-1], high_speed})) ? high_speed
                                                                        : speed_sum[RW-1:0];
    end else if (decel_on) begin
      speed_next = (speed_sum < $signed({low_speed[RW-1], low_speed})) ? low_speed
                                                                      : speed_sum[RW-1:0];
    end else begin
      speed_next = velocity;
    end
  end

  // step cut at the end and saturating accumulate
  always_comb begin
    if (!endless_mode && (left < $signed({2'b00, prod[DW-1:0]}))) begin
      step_next = left[DW-1:0];
    end else begin
      step_next = prod[DW-1:0];
    end
    done_sum = {1'b0, done_dist} + {1'b0, step_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      velocity  <= '0;
      done_dist <= '0;
      m_tvalid  <= 1'b0;
      accel_on  <= 1'b0;
      decel_on  <= 1'b0;
    end else begin
      if (state == ST_PUSH && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            tick  <= s_tdata[TW-1:0];
            left  <= $signed({2'b00, total_distance}) - $signed({2'b00, done_dist});
            state <= ST_RAMP;
          end
        end
        ST_RAMP: begin
          accel_on <= accel_c;
          decel_on <= decel_c;
          if (moving) begin
            state <= ST_ADD;
          end else begin
            step  <= '0;
            state <= ST_PUSH;
          end
        end
        ST_ADD: begin
          velocity <= speed_next;
          state    <= ST_STEP;
        end
        ST_STEP: begin
          if (velocity > 0) begin
            state <= ST_FIN;
          end else begin
            step  <= '0;
            state <= ST_PUSH;
          end
        end
        ST_FIN: begin
          step      <= step_next;
          done_dist <= done_sum[DW] ? {DW{1'b1}} : done_sum[DW-1:0];
          state     <= ST_PUSH;
        end
        ST_PUSH: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {2'b00, done_dist, velocity, step};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/tmp_mul.sv
// Shared Q16.16 by Q0.16 multiplier, truncating toward zero, registered result.
`timescale 1ns / 1ps
module tmp_mul (
  input  logic                                   clk,
  input  logic signed [tmp_pkg::RATE_W-1:0]      a,
  input  logic        [tmp_pkg::TICK_W-1:0]      dt,
  output logic signed [tmp_pkg::RATE_W-1:0]      prod
);

  logic signed [tmp_pkg::PROD_W-1:0] full;
  logic signed [tmp_pkg::PROD_W-1:0] adj;

  always_comb begin
    full = $signed({{(tmp_pkg::PROD_W-tmp_pkg::RATE_W){a[tmp_pkg::RATE_W-1]}}, a})
         * $signed({{(tmp_pkg::PROD_W-tmp_pkg::TICK_W){1'b0}}, dt});
    // bias negative products so the shift truncates toward zero
    if (full[tmp_pkg::PROD_W-1]) begin
      adj = full + $signed({{(tmp_pkg::PROD_W-tmp_pkg::FRAC_W){1'b0}},
                            {tmp_pkg::FRAC_W{1'b1}}});
    end else begin
      adj = full;
    end
  end

  always_ff @(posedge clk) begin
    prod <= adj[tmp_pkg::FRAC_W + tmp_pkg::RATE_W - 1:tmp_pkg::FRAC_W];
  end

endmodule
